// ===== design/vra_pkg.sv =====
`default_nettype none
package vra_pkg;

    // Request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NOSPACE = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    // Pair requests get the odd-start skip
    localparam int unsigned PAIR_LEN = 2;

    // One pool entry as held in the voice table
    typedef struct packed {
        logic       in_use;
        logic [3:0] kind_flags;
    } t_voice_entry;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CAND,
        ST_CHECK,
        ST_WRITE,
        ST_RESULT
    } t_state;

endpackage
`default_nettype wire

// ===== design/voice_run_allocator.sv =====
`default_nettype none
// Channel | Handshake               | Fields
// --------+-------------------------+----------------------------------------------------
// request | i_in_valid, o_in_ready  | i_opcode, i_voice_kind, i_run_length, i_voice_index
// result  | o_out_valid, i_out_ready| o_status, o_run_base
//
// One request at a time. A free or a rejected count goes straight to the result state; an
// allocation walks the voice table one entry per cycle, passing through the candidate state
// for each candidate start and each odd pair skip, then writes one entry per cycle for the
// run. The voice table has a single read port.
// After reset a clearing pass zeroes every table entry before o_in_ready rises.
// A result waiting in the output register does not block the next request; a finished
// request holds in the result state until the output register is free.
module voice_run_allocator
    import vra_pkg::*;
#(
    parameter int VOICE_COUNT = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_opcode,
    input  wire logic [1:0] i_voice_kind,
    input  wire logic [6:0] i_run_length,
    input  wire logic [5:0] i_voice_index,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [1:0]      o_status,
    output logic [5:0]      o_run_base
);

    localparam int PW = $clog2(VOICE_COUNT);
    localparam int LW = PW + 1;
    localparam logic [LW-1:0] N_L  = LW'(VOICE_COUNT);
    localparam logic [8:0]    N_9  = 9'(VOICE_COUNT);
    localparam logic [LW-1:0] PAIR = LW'(PAIR_LEN);

    t_state         r_state, n_state;
    logic [PW-1:0]  r_pos, n_pos;
    logic [LW-1:0]  r_off, n_off;
    logic [LW-1:0]  r_prog, n_prog;
    logic [LW-1:0]  r_len, n_len;
    logic [1:0]     r_kind, n_kind;
    logic [PW-1:0]  r_scan_start, n_scan_start;
    logic [1:0]     r_res_status, n_res_status;
    logic [5:0]     r_res_first, n_res_first;
    logic           r_out_valid;
    logic [1:0]     r_o_status;
    logic [5:0]     r_o_first;
    logic           out_load;

    logic           wr_en;
    logic [PW-1:0]  wr_addr;
    t_voice_entry   wr_data;
    logic [PW-1:0]  rd_addr;
    t_voice_entry   rd_data;

    logic           in_acc;
    logic [LW-1:0]  cur_voice, next_voice, next_cand, pair_cand;

    // Sum below twice the pool size folded back into the pool
    function automatic logic [LW-1:0] f_wrap(input logic [LW-1:0] s);
        return (s >= N_L) ? (s - N_L) : s;
    endfunction

    vra_ram #(
        .DEPTH (VOICE_COUNT),
        .AW    (PW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_in_ready    = (r_state == ST_IDLE);
    assign in_acc        = i_in_valid && o_in_ready;
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_run_base    = r_o_first;

    // Voice addresses around the current candidate
    assign cur_voice  = f_wrap({1'b0, r_pos} + r_off);
    assign next_voice = f_wrap({1'b0, r_pos} + r_off + LW'(1));
    assign next_cand  = f_wrap({1'b0, r_pos} + r_len);
    // Odd pair start: bump to even, then the usual step as well
    assign pair_cand  = f_wrap({1'b0, r_pos} + PAIR + LW'(1));

    // State register and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_off        <= '0;
            r_scan_start <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_off        <= n_off;
            r_scan_start <= n_scan_start;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_prog       <= n_prog;
        r_len        <= n_len;
        r_kind       <= n_kind;
        r_res_status <= n_res_status;
        r_res_first  <= n_res_first;
        if (out_load) begin
            r_o_status <= r_res_status;
            r_o_first  <= r_res_first;
        end
    end

    // Next state, table accesses
    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_off        = r_off;
        n_prog       = r_prog;
        n_len        = r_len;
        n_kind       = r_kind;
        n_scan_start = r_scan_start;
        n_res_status = r_res_status;
        n_res_first  = r_res_first;
        out_load     = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = cur_voice[PW-1:0];
        wr_data      = '0;
        rd_addr      = r_pos;

        case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_off[PW-1:0];
                if (r_off == N_L - LW'(1)) begin
                    n_off   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_off = r_off + LW'(1);
                end
            end

            ST_IDLE: begin
                if (in_acc) begin
                    n_res_first = '0;
                    n_state     = ST_RESULT;
                    if (i_opcode == OP_FREE) begin
                        if ({3'b000, i_voice_index} < N_9) begin
                            wr_en        = 1'b1;
                            wr_addr      = PW'(i_voice_index);
                            n_res_status = STATUS_OK;
                        end else begin
                            n_res_status = STATUS_INVALID;
                        end
                    end else if (i_run_length == 7'd0 || {2'b00, i_run_length} > N_9) begin
                        n_res_status = STATUS_INVALID;
                    end else begin
                        n_len   = LW'(i_run_length);
                        n_kind  = i_voice_kind;
                        n_pos   = r_scan_start;
                        n_prog  = '0;
                        n_off   = '0;
                        n_state = ST_CAND;
                    end
                end
            end

            // New candidate start: limit, pair skip, or first read
            ST_CAND: begin
                if (r_prog >= N_L) begin
                    n_res_status = STATUS_NOSPACE;
                    n_state      = ST_RESULT;
                end else if (r_len == PAIR && r_pos[0]) begin
                    n_pos  = pair_cand[PW-1:0];
                    n_prog = r_prog + PAIR;
                end else begin
                    rd_addr = r_pos;
                    n_off   = '0;
                    n_state = ST_CHECK;
                end
            end

            // Test one voice of the candidate run per cycle
            ST_CHECK: begin
                if (rd_data.in_use) begin
                    n_pos   = next_cand[PW-1:0];
                    n_prog  = r_prog + r_len;
                    n_off   = '0;
                    n_state = ST_CAND;
                end else if (r_off + LW'(1) == r_len) begin
                    n_off   = '0;
                    n_state = ST_WRITE;
                end else begin
                    n_off   = r_off + LW'(1);
                    rd_addr = next_voice[PW-1:0];
                end
            end

            // Mark the run, one voice per cycle
            ST_WRITE: begin
                wr_en              = 1'b1;
                wr_addr            = cur_voice[PW-1:0];
                wr_data.in_use     = 1'b1;
                wr_data.kind_flags = 4'b0001 << r_kind;
                if (r_off + LW'(1) == r_len) begin
                    n_off        = '0;
                    n_res_status = STATUS_OK;
                    n_res_first  = 6'(r_pos);
                    n_scan_start = next_cand[PW-1:0];
                    n_state      = ST_RESULT;
                end else begin
                    n_off = r_off + LW'(1);
                end
            end

            ST_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/vra_ram.sv =====
`default_nettype none
module vra_ram
    import vra_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic         i_clk,
    input  wire logic         i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_voice_entry i_wr_data,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_voice_entry      o_rd_data
);

    t_voice_entry r_mem [DEPTH];

    // Single write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire
